FILE: rtl/ilbes_pkg.sv
// ----------------------------------------------------------------------------
// ilbes_pkg
// shared types and constants of the icon list best entry select block
// ----------------------------------------------------------------------------
package ilbes_pkg;

   localparam int unsigned MAX_CARDS_DEF  = 1048576;
   localparam int unsigned CARD_W         = 32;
   localparam int unsigned SIDE_CFG_W     = 16;
   localparam int unsigned OFFSET_OUT_W   = 20;
   localparam logic [SIDE_CFG_W-1:0] MAX_SIDE_RESET = 16'd64;

   typedef enum logic [1:0] {
      PH_WIDTH,
      PH_HEIGHT,
      PH_PIXELS,
      PH_STOPPED
   } phase_type;

   typedef struct packed {
      logic [OFFSET_OUT_W-1:0] best_offset;
      logic [SIDE_CFG_W-1:0]   chosen_side;
      logic                    found;
   } result_type;

endpackage

FILE: rtl/ilbes_walk.sv
// ----------------------------------------------------------------------------
// ilbes_walk
// list walker: header checks, pixel countdown and best square entry tracking
// ----------------------------------------------------------------------------
module ilbes_walk #(
   parameter int unsigned MAX_CARDS = ilbes_pkg::MAX_CARDS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic [ilbes_pkg::CARD_W-1:0]         card,
   input  logic                                 last,
   input  logic [ilbes_pkg::SIDE_CFG_W-1:0]     max_side,
   output ilbes_pkg::result_type                result
);

   localparam int unsigned POS_W  = $clog2(MAX_CARDS + 1);
   localparam int unsigned OFS_W  = $clog2(MAX_CARDS);
   localparam int unsigned SIDE_W = ($clog2(MAX_CARDS) + 2) / 2;
   localparam int unsigned PIX_W  = 2 * SIDE_W;
   localparam int unsigned CHK_W  = ((POS_W > PIX_W) ? POS_W : PIX_W) + 1;

   ilbes_pkg::phase_type phase_ff, phase_in, walk_phase;
   logic [SIDE_W-1:0] side_ff, side_in, walk_side;
   logic [OFS_W-1:0]  offset_ff, offset_in, walk_offset;
   logic [PIX_W-1:0]  pixels_ff, pixels_in, walk_pixels;
   logic [POS_W-1:0]  position_ff, position_in, walk_position;
   logic [ilbes_pkg::SIDE_CFG_W-1:0] chosen_side_ff, chosen_side_in, walk_chosen_side;
   logic [OFS_W-1:0]  best_offset_ff, best_offset_in, walk_best_offset;

   logic [PIX_W-1:0] square;
   logic [PIX_W-1:0] pix_dec;
   logic [CHK_W-1:0] entry_end;
   logic             in_range;

   assign square    = PIX_W'(side_ff) * PIX_W'(side_ff);
   assign pix_dec   = pixels_ff - PIX_W'(1);
   assign entry_end = CHK_W'(offset_ff) + CHK_W'(2) + CHK_W'(square);
   assign in_range  = position_ff < POS_W'(MAX_CARDS);

   always_comb begin
      walk_phase       = phase_ff;
      walk_side        = side_ff;
      walk_offset      = offset_ff;
      walk_pixels      = pixels_ff;
      walk_position    = position_ff;
      walk_chosen_side = chosen_side_ff;
      walk_best_offset = best_offset_ff;
      if (in_range) begin
         walk_position = position_ff + POS_W'(1);
         unique case (phase_ff)
            ilbes_pkg::PH_WIDTH: begin
               // a zero width stops now, as does a side this wide that can never fit
               if (card == '0 || card[ilbes_pkg::CARD_W-1:SIDE_W] != '0) begin
                  walk_phase = ilbes_pkg::PH_STOPPED;
               end else begin
                  walk_side   = card[SIDE_W-1:0];
                  walk_offset = position_ff[OFS_W-1:0];
                  walk_phase  = ilbes_pkg::PH_HEIGHT;
               end
            end
            ilbes_pkg::PH_HEIGHT: begin
               if (card != ilbes_pkg::CARD_W'(side_ff)) begin
                  walk_phase = ilbes_pkg::PH_STOPPED;
               end else if (entry_end > CHK_W'(MAX_CARDS)) begin
                  walk_phase = ilbes_pkg::PH_STOPPED;
               end else begin
                  walk_pixels = square;
                  walk_phase  = ilbes_pkg::PH_PIXELS;
               end
            end
            ilbes_pkg::PH_PIXELS: begin
               walk_pixels = pix_dec;
               if (pix_dec == '0) begin
                  walk_phase = ilbes_pkg::PH_WIDTH;
                  // larger side means larger area
                  if (ilbes_pkg::SIDE_CFG_W'(side_ff) <= max_side &&
                      ilbes_pkg::SIDE_CFG_W'(side_ff) > chosen_side_ff) begin
                     walk_chosen_side = ilbes_pkg::SIDE_CFG_W'(side_ff);
                     walk_best_offset = offset_ff;
                  end
               end
            end
            ilbes_pkg::PH_STOPPED: begin
               walk_phase = ilbes_pkg::PH_STOPPED;
            end
         endcase
      end
   end

   assign result.best_offset = ilbes_pkg::OFFSET_OUT_W'(walk_best_offset);
   assign result.chosen_side = walk_chosen_side;
   assign result.found       = walk_chosen_side != '0;

   always_comb begin
      if (last) begin
         phase_in       = ilbes_pkg::PH_WIDTH;
         side_in        = '0;
         offset_in      = '0;
         pixels_in      = '0;
         position_in    = '0;
         chosen_side_in = '0;
         best_offset_in = '0;
      end else begin
         phase_in       = walk_phase;
         side_in        = walk_side;
         offset_in      = walk_offset;
         pixels_in      = walk_pixels;
         position_in    = walk_position;
         chosen_side_in = walk_chosen_side;
         best_offset_in = walk_best_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ilbes_pkg::PH_WIDTH;
         side_ff        <= '0;
         offset_ff      <= '0;
         pixels_ff      <= '0;
         position_ff    <= '0;
         chosen_side_ff <= '0;
         best_offset_ff <= '0;
      end else if (take) begin
         phase_ff       <= phase_in;
         side_ff        <= side_in;
         offset_ff      <= offset_in;
         pixels_ff      <= pixels_in;
         position_ff    <= position_in;
         chosen_side_ff <= chosen_side_in;
         best_offset_ff <= best_offset_in;
      end
   end

endmodule

FILE: rtl/icon_list_best_entry_select_top.sv
// ----------------------------------------------------------------------------
// icon_list_best_entry_select_top
// picks the largest square icon entry, no wider than max_side, from a list
// ----------------------------------------------------------------------------
// usage
//   req channel: one 32-bit card per item with req_last on the final card of
//   the list. the list is width, height and width*height pixel cards, repeated.
//   rsp channel: one item per list, after its last card: offset of the chosen
//   entry's width card, its side, and found.
//   csr: csr_wr_en / csr_wr_data write max_side; write only while idle.
//   throughput: one card per cycle while req_ready is high.
//   the result is written into the output buffer as the last card is taken.
//   a two-entry output buffer lets cards keep flowing while a result waits;
//   req_ready drops only when both entries hold results rsp has not taken.
//   reset: walk state clears, buffer empties, max_side returns to 64.
//   after each result the walk restarts at offset 0 for the next list.
// ----------------------------------------------------------------------------
module icon_list_best_entry_select_top #(
   parameter int unsigned MAX_CARDS = ilbes_pkg::MAX_CARDS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ilbes_pkg::CARD_W-1:0]           req_card,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ilbes_pkg::OFFSET_OUT_W-1:0]     rsp_best_offset,
   output logic [ilbes_pkg::SIDE_CFG_W-1:0]       rsp_chosen_side,
   output logic                                   rsp_found,
   input  logic                                   csr_wr_en,
   input  logic [ilbes_pkg::SIDE_CFG_W-1:0]       csr_wr_data
);

   logic [ilbes_pkg::SIDE_CFG_W-1:0] max_side_ff;
   ilbes_pkg::result_type walk_result;
   ilbes_pkg::result_type out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic take, push, pop;

   assign req_ready = !skid_valid_ff;
   assign take      = req_valid && req_ready;
   assign push      = take && req_last;
   assign pop       = out_valid_ff && rsp_ready;

   ilbes_walk #(
      .MAX_CARDS (MAX_CARDS)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .card     (req_card),
      .last     (req_last),
      .max_side (max_side_ff),
      .result   (walk_result)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff && !out_valid_in) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!out_valid_in) begin
            out_in       = walk_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = walk_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         max_side_ff   <= ilbes_pkg::MAX_SIDE_RESET;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_wr_en) begin
            max_side_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_best_offset = out_ff.best_offset;
   assign rsp_chosen_side = out_ff.chosen_side;
   assign rsp_found       = out_ff.found;

endmodule
